// File: rtl/mmh_pkg.sv
// mmh_pkg: shared types and constants for the min-max heap.
// No dependencies.
package mmh_pkg;
  localparam int CAPACITY  = 1024;
  localparam int KEY_WIDTH = 32;
  localparam int AW        = $clog2(CAPACITY + 1);   // slot index width (1-based)
  localparam int CW        = 11;                     // entry_count width

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_POP_MIN = 2'd1,
    REQ_POP_MAX = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } mmh_in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic               was_empty;
    logic               overflow;
    logic [CW-1:0]      entry_count;
    logic signed [31:0] current_min;
    logic signed [31:0] current_max;
  } mmh_out_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_RD,     // read slot addr
    OP_WR,     // write wr_data into slot addr
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t           op;
    logic [AW-1:0] addr;
  } mem_cmd_t;
endpackage

// File: rtl/mmh_datapath.sv
// mmh_datapath: key memory with one registered read port.
// Depends on mmh_pkg.
module mmh_datapath (
  input  logic              clk,
  input  mmh_pkg::mem_cmd_t cmd,
  input  logic [mmh_pkg::KEY_WIDTH-1:0] wr_data,
  output logic [mmh_pkg::KEY_WIDTH-1:0] rd_data
);
  import mmh_pkg::*;
  logic [KEY_WIDTH-1:0] mem [1:CAPACITY];

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WR) begin
      mem[cmd.addr] <= wr_data;
    end
    rd_data <= mem[cmd.addr];
  end
endmodule

// File: rtl/mmh_ctrl.sv
// mmh_ctrl: sequencer for insert / pop sift operations, holds the count; keys are stored in mmh_datapath.
// Depends on mmh_pkg; drives mmh_datapath through mem_cmd_t.
module mmh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mmh_pkg::mmh_in_t  req,
  output logic              busy,
  output logic              done,
  output mmh_pkg::mmh_out_t result,
  output mmh_pkg::mem_cmd_t cmd,
  output logic [mmh_pkg::KEY_WIDTH-1:0] wr_data,
  input  logic [mmh_pkg::KEY_WIDTH-1:0] rd_data
);
  import mmh_pkg::*;
  localparam int KW = KEY_WIDTH;
  localparam int EW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

  typedef enum logic [4:0] {
    S_IDLE, S_INS, S_UP_P, S_UP_PW, S_UP_CMP, S_UP_GP, S_UP_GPW, S_UP_GCMP,
    S_POP, S_POP_LW, S_DN_RD, S_DN_RW, S_DN_CMP, S_DN_FIX, S_DN_FW,
    S_HD1, S_HD2, S_HD3, S_HD3W, S_DONE
  } state_t;

  state_t state;
  logic [CW-1:0]  cnt;
  logic [AW-1:0]  cur, best, wa;
  logic [2:0]     k;
  logic           mn;          // current level is a min level
  logic [1:0]     rq;
  logic signed [KW-1:0] key, bk, popped, h1, h2;
  logic           ovf, emp;
  logic           rdv;

  function automatic logic min_lvl(input logic [AW-1:0] i);
    int l;
    l = 0;
    for (int b = 0; b < AW; b++) if (i[b]) l = b;
    return (l[0] == 1'b0);
  endfunction

  function automatic logic ahead(input logic signed [KW-1:0] a, b, input logic m);
    return m ? (a < b) : (a > b);
  endfunction

  function automatic logic [AW-1:0] cand(input logic [AW-1:0] i, input logic [2:0] n);
    logic [AW+1:0] v;
    v = (n < 3'd2) ? {1'b0, i, 1'b0} + (AW+2)'(n) : {i, 2'b00} + (AW+2)'(n - 3'd2);
    return (v > (AW+2)'(cnt)) ? '0 : v[AW-1:0];
  endfunction

  logic signed [KW-1:0] rdk;
  assign rdk = rd_data;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= '0; done <= 1'b0; cmd <= '{OP_IDLE, '0};
    end else begin
      done <= 1'b0;
      cmd  <= '{OP_IDLE, cur};
      unique case (state)
        S_IDLE: if (start) begin
          rq <= req.req_type; ovf <= 1'b0; emp <= 1'b0; popped <= '0;
          key <= KW'($signed(req.value[EW-1:0]));
          unique case (req.req_type)
            REQ_INSERT: if (cnt >= CW'(CAPACITY)) begin ovf <= 1'b1; state <= S_HD1; end
                        else begin cnt <= cnt + 1'b1; cur <= AW'(cnt + 1'b1); state <= S_INS; end
            REQ_POP_MIN, REQ_POP_MAX: if (cnt == '0) begin
              emp <= 1'b1; popped <= '1; state <= S_HD1;
            end else begin
              cmd <= '{OP_RD, AW'(cnt)}; state <= S_POP;
            end
            default: state <= S_HD1;
          endcase
        end
        // insert: compare with parent
        S_INS: begin
          if (cur == AW'(1)) begin cmd <= '{OP_WR, cur}; wr_data <= key; state <= S_HD1; end
          else begin cmd <= '{OP_RD, cur >> 1}; state <= S_UP_PW; end
        end
        S_UP_PW: state <= S_UP_CMP;
        S_UP_CMP: begin
          if (min_lvl(cur) ? (key > rdk) : (key < rdk)) begin
            cmd <= '{OP_WR, cur}; wr_data <= rdk; cur <= cur >> 1;
            mn <= ~min_lvl(cur);
          end else mn <= min_lvl(cur);
          state <= S_UP_GP;
        end
        S_UP_GP: begin
          if ((cur >> 2) == '0) begin cmd <= '{OP_WR, cur}; wr_data <= key; state <= S_HD1; end
          else begin cmd <= '{OP_RD, cur >> 2}; state <= S_UP_GPW; end
        end
        S_UP_GPW: state <= S_UP_GCMP;
        S_UP_GCMP: begin
          if (ahead(key, rdk, mn)) begin
            cmd <= '{OP_WR, cur}; wr_data <= rdk; cur <= cur >> 2; state <= S_UP_GP;
          end else begin cmd <= '{OP_WR, cur}; wr_data <= key; state <= S_HD1; end
        end
        // pop: last key read issued; fetch root or slot 2/3 candidates
        S_POP: begin
          k <= 3'd0; rdv <= 1'b0; state <= S_POP_LW;
          cmd <= '{OP_RD, AW'(1)};
        end
        S_POP_LW: begin
          // rdk holds last key this cycle; gather root / slots 2,3
          if (!rdv) begin
            key <= rdk; rdv <= 1'b1; cmd <= '{OP_RD, AW'(2)};
          end else if (k == 3'd0) begin
            h1 <= rdk; k <= 3'd1; cmd <= '{OP_RD, AW'(3)};
          end else if (k == 3'd1) begin
            h2 <= rdk; k <= 3'd2;
          end else begin
            cnt <= cnt - 1'b1;
            if (rq == REQ_POP_MIN) begin
              popped <= h1; cur <= AW'(1);
              if (cnt == CW'(1)) state <= S_HD1; else state <= S_DN_RD;
            end else if (cnt == CW'(1)) begin popped <= h1; state <= S_HD1; end
            else if (cnt == CW'(2)) begin popped <= h2; state <= S_HD1; end
            else begin
              popped <= (rdk > h2) ? rdk : h2;
              cur <= (rdk > h2) ? AW'(3) : AW'(2);
              if (((rdk > h2) ? CW'(3) : CW'(2)) > cnt - 1'b1) state <= S_HD1;
              else state <= S_DN_RD;
            end
          end
        end
        // sift down: scan six candidates, key held in register (hole at cur)
        S_DN_RD: begin
          mn <= min_lvl(cur); best <= cur; bk <= key; k <= 3'd0;
          cmd <= '{OP_RD, cand(cur, 3'd0)}; state <= S_DN_RW;
        end
        S_DN_RW: begin
          cmd <= '{OP_RD, cand(cur, 3'd1)}; k <= 3'd1; state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (cand(cur, k - 3'd1) != '0 && ahead(rdk, bk, mn)) begin
            bk <= rdk; best <= cand(cur, k - 3'd1);
          end
          if (k == 3'd6) begin
            state <= S_DN_FIX;
          end else begin
            cmd <= '{OP_RD, (k == 3'd5) ? '0 : cand(cur, k + 3'd1)};
            k <= k + 3'd1;
          end
        end
        S_DN_FIX: begin
          if (best == cur) begin
            cmd <= '{OP_WR, cur}; wr_data <= key; state <= S_HD1;
          end else begin
            cmd <= '{OP_WR, cur}; wr_data <= bk;
            if (best < {cur, 2'b00}) begin
              wa <= best; state <= S_DN_FW;      // child: place key, stop
              k <= 3'd7;
            end else begin
              wa <= best; k <= 3'd0; state <= S_DN_FW;
            end
          end
        end
        S_DN_FW: begin
          if (k == 3'd7) begin
            cmd <= '{OP_WR, wa}; wr_data <= key; state <= S_HD1;
          end else if (k == 3'd0) begin
            cmd <= '{OP_RD, wa >> 1}; k <= 3'd1;
          end else if (k == 3'd1) k <= 3'd2;
          else begin
            // rdk = parent of grandchild slot
            if (ahead(rdk, key, mn)) begin
              cmd <= '{OP_WR, wa >> 1}; wr_data <= key; key <= rdk;
            end
            cur <= wa; state <= S_DN_RD;
          end
        end
        // refresh min/max from slots 1..3
        S_HD1: begin cmd <= '{OP_RD, AW'(1)}; state <= S_HD2; end
        S_HD2: begin cmd <= '{OP_RD, AW'(2)}; state <= S_HD3; end
        S_HD3: begin h1 <= rdk; cmd <= '{OP_RD, AW'(3)}; state <= S_HD3W; end
        S_HD3W: begin h2 <= rdk; state <= S_DONE; end
        S_DONE: begin
          result.popped_value <= 32'(popped);
          result.was_empty <= emp;
          result.overflow <= ovf;
          result.entry_count <= cnt;
          result.current_min <= (cnt == '0) ? '1 : 32'(h1);
          result.current_max <= (cnt == '0) ? '1 : (cnt == CW'(1)) ? 32'(h1) :
                                (cnt == CW'(2)) ? 32'(h2) : ((rdk > h2) ? 32'(rdk) : 32'(h2));
          done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/min_max_heap.sv
// min_max_heap: top level, double-ended priority queue (min-max heap).
// Depends on mmh_pkg, mmh_ctrl, mmh_datapath.
//
//  channel  | handshake        | payload
//  request  | start / busy     | req   (mmh_in_t)
//  result   | done (1 cycle)   | result (mmh_out_t)
//
// One request at a time; busy drops in the cycle that carries the result strobe.
// Busy time grows with the sift: an insert adds grandparent swaps, a pop adds
// grandchild steps descended; overflow, unknown requests and empty pops do no
// sift at all.
// The memory has a single registered port (one key read per cycle).
// Reset clears the count and control state, not the keys; stored keys are never used before written.
// The receiver cannot stall: each result transaction shows for one cycle.
module min_max_heap (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mmh_pkg::mmh_in_t  req,
  output logic              busy,
  output logic              done,
  output mmh_pkg::mmh_out_t result
);
  import mmh_pkg::*;
  mem_cmd_t cmd;
  logic [KEY_WIDTH-1:0] wr_data, rd_data;

  mmh_ctrl u_ctrl (.clk, .rst, .start, .req, .busy, .done, .result,
                   .cmd, .wr_data, .rd_data);
  mmh_datapath u_dp (.clk, .cmd, .wr_data, .rd_data);
endmodule

// File: rtl/mmh_checker.sv
// mmh_checker: port-level assertions for min_max_heap, bound to the top.
// Depends on mmh_pkg.
module mmh_checker (
  input logic clk, input logic rst, input logic start, input logic busy,
  input logic done, input mmh_pkg::mmh_out_t result
);
  import mmh_pkg::*;
  a_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("no busy after accept");
  a_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.was_empty && result.overflow)) else $error("both flags");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> result.entry_count <= CW'(CAPACITY)) else $error("count beyond capacity");
endmodule

bind min_max_heap mmh_checker u_chk (.clk, .rst, .start, .busy, .done, .result);
